/* src/pdlq_pkg.sv */
// Shared types and constants for the priority delay and loss queue block.
// Used by the shared arithmetic unit and by the top level; depends on nothing.
package pdlq_pkg;

	localparam int NQ            = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int TAG_OUT_BITS  = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_BASE    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_STEP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DELIVER_ABOVE = 3'd3;

	localparam logic [6:0]  LIMIT_RST   = 7'd64;
	localparam logic [15:0] BASE_RST    = 16'd100;
	localparam logic [7:0]  STEP_RST    = 8'd10;
	localparam logic [3:0]  DELIVER_RST = 4'd1;

	localparam logic       KIND_ARRIVAL = 1'b0;
	localparam logic       KIND_TICK    = 1'b1;
	localparam logic [7:0] PRIO_MIN     = 8'd1;
	localparam logic [7:0] PRIO_MAX     = 8'd3;
	localparam logic [1:0] Q_LAST       = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_CMP,
		ST_QSTART,
		ST_POP_OUT,
		ST_ARM_A,
		ST_ARM_B
	} st_t;

	typedef enum logic [1:0] {
		EV_QUEUED    = 2'd0,
		EV_DROP_FULL = 2'd1,
		EV_DELIVERED = 2'd2,
		EV_DROP_RAND = 2'd3
	} ev_t;

	typedef enum logic {
		ALU_ADD,
		ALU_LT
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        lt;
	} alu_res_t;

endpackage

/* src/pdlq_alu.sv */
// Shared 32-bit adder and unsigned comparator used by the queue sequencer.
// Depends on pdlq_pkg for the request and result types.
module pdlq_alu (
	input  pdlq_pkg::alu_req_t req,
	output pdlq_pkg::alu_res_t res
);
	import pdlq_pkg::*;

	logic [32:0] sum_w;

	// For the compare, a - b is formed; a missing carry out means a < b.
	always_comb begin
		unique case (req.op)
			ALU_ADD: sum_w = {1'b0, req.a} + {1'b0, req.b};
			ALU_LT:  sum_w = {1'b0, req.a} + {1'b0, ~req.b} + 33'd1;
			default: sum_w = '0;
		endcase
		res.sum = sum_w[31:0];
		res.lt  = (req.op == ALU_LT) && !sum_w[32];
	end

endmodule

/* src/pdlq_tag_ram.sv */
// Tag store for all three queues: one write port, one read port, registered read data.
// Stands alone; no package needed.
module pdlq_tag_ram #(
	parameter int DEPTH = 192,
	parameter int WIDTH = 16,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/priority_delay_loss_queues.sv */
// Top level: three priority FIFOs of packet tags with head delay and random loss.
// Depends on pdlq_pkg, pdlq_alu and pdlq_tag_ram.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     kind, priority_req, packet_tag, now_ms, picks
//   out      out_valid / out_ready   event_res, queue_id, tag_out, last
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An arrival passes through ST_IDLE and ST_ARRIVE; an ignored item or a tick at time zero stays in ST_IDLE.
// A tick passes through ST_IDLE, then ST_CMP once per queue, then per queue ST_QSTART,
// ST_POP_OUT if the head pops (the tag store is read in ST_QSTART), and ST_ARM_A plus,
// when the head must be armed, ST_ARM_B for the arming add on the shared 32-bit adder.
// The sequencer handles one item at a time; a full output register stalls it.
// Reset clears all queues, pointers and arming; the tag store is not cleared.
module priority_delay_loss_queues #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  priority_req,
	input  logic [15:0] packet_tag,
	input  logic [31:0] now_ms,
	input  logic [6:0]  delay_pick_one,
	input  logic [6:0]  delay_pick_two,
	input  logic [6:0]  delay_pick_three,
	input  logic [3:0]  drop_pick_one,
	input  logic [3:0]  drop_pick_two,
	input  logic [3:0]  drop_pick_three,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic [1:0]  queue_id,
	output logic [15:0] tag_out,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pdlq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pdlq_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import pdlq_pkg::*;

	localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SW    = CW + 1;
	localparam int LW    = (CW > 7) ? CW : 7;
	localparam int DEPTH = NQ * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers.
	logic [6:0]  cfg_limit_q;
	logic [15:0] cfg_base_q;
	logic [7:0]  cfg_step_q;
	logic [3:0]  cfg_deliver_q;

	// Queue state.
	logic [PW-1:0] rp_q       [NQ];
	logic [CW-1:0] fill_q     [NQ];
	logic [31:0]   deadline_q [NQ];
	logic [NQ-1:0] armed_q;
	logic [NQ-1:0] pop_q;

	// Sequencer and captured item.
	st_t         state_q, state_d;
	logic [1:0]  q_q, q_d;
	logic [15:0] tag_q;
	logic [31:0] now_q;
	logic [6:0]  dpick_q [NQ];
	logic [3:0]  xpick_q [NQ];
	logic [31:0] acc_q;
	logic [14:0] prod_q;

	// Output register.
	logic        out_valid_q;
	ev_t         ev_q;
	logic [1:0]  qid_q;
	logic [15:0] tagout_q;
	logic        last_q;

	logic        emit;
	ev_t         ev_d;
	logic [15:0] tagout_d;
	logic        last_d;
	logic        out_free;
	logic        room;
	logic        last_pop;
	logic        ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [TAG_BITS-1:0] ram_wdata, ram_rdata;
	logic [15:0]         rd16, arr16;
	logic [SW-1:0]       slot_sum, slot_w;
	logic [PW-1:0]       slot;
	alu_req_t            alu_req;
	alu_res_t            alu_res;

	logic [PW-1:0] rp_cur;
	logic [CW-1:0] fill_cur;
	logic [31:0]   deadline_cur;
	logic          armed_cur;

	assign rp_cur       = rp_q[q_q];
	assign fill_cur     = fill_q[q_q];
	assign deadline_cur = deadline_q[q_q];
	assign armed_cur    = armed_q[q_q];

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// Room is checked against the limit and the physical depth, whichever is lower.
	assign room = (LW'(fill_cur) < LW'(cfg_limit_q)) && (LW'(fill_cur) < LW'(QUEUE_DEPTH));

	assign slot_sum  = SW'(rp_cur) + SW'(fill_cur);
	assign slot_w    = (slot_sum >= SW'(QUEUE_DEPTH)) ? slot_sum - SW'(QUEUE_DEPTH) : slot_sum;
	assign slot      = slot_w[PW-1:0];
	assign ram_waddr = AW'(q_q) * AW'(QUEUE_DEPTH) + AW'(slot);
	assign ram_raddr = AW'(q_q) * AW'(QUEUE_DEPTH) + AW'(rp_cur);

	generate
		if (TAG_BITS >= TAG_OUT_BITS) begin : g_tag_wide
			assign ram_wdata = TAG_BITS'(tag_q);
			assign rd16      = ram_rdata[TAG_OUT_BITS-1:0];
			assign arr16     = tag_q;
		end else begin : g_tag_narrow
			assign ram_wdata = tag_q[TAG_BITS-1:0];
			assign rd16      = {{(TAG_OUT_BITS-TAG_BITS){1'b0}}, ram_rdata};
			assign arr16     = {{(TAG_OUT_BITS-TAG_BITS){1'b0}}, tag_q[TAG_BITS-1:0]};
		end
	endgenerate

	// The result is last when no later queue pops on this tick.
	always_comb begin
		last_pop = 1'b1;
		for (int i = 0; i < NQ; i++) begin
			if (2'(i) > q_q && pop_q[i]) begin
				last_pop = 1'b0;
			end
		end
	end

	pdlq_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	pdlq_tag_ram #(
		.DEPTH (DEPTH),
		.WIDTH (TAG_BITS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			q_q     <= '0;
		end else begin
			state_q <= state_d;
			q_q     <= q_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_d      = q_q;
		in_ready = 1'b0;
		emit     = 1'b0;
		ev_d     = EV_QUEUED;
		tagout_d = arr16;
		last_d   = 1'b1;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		alu_req  = '{op: ALU_LT, a: deadline_cur, b: now_q};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_TICK) begin
						q_d = '0;
						if (now_ms != '0) begin
							state_d = ST_CMP;
						end
					end else begin
						q_d = priority_req[1:0] - 2'd1;
						if (priority_req >= PRIO_MIN && priority_req <= PRIO_MAX) begin
							state_d = ST_ARRIVE;
						end
					end
				end
			end
			ST_ARRIVE: begin
				if (out_free) begin
					emit    = 1'b1;
					ev_d    = room ? EV_QUEUED : EV_DROP_FULL;
					ram_we  = room;
					state_d = ST_IDLE;
				end
			end
			ST_CMP: begin
				if (q_q == Q_LAST) begin
					q_d     = '0;
					state_d = ST_QSTART;
				end else begin
					q_d = q_q + 2'd1;
				end
			end
			ST_QSTART: begin
				if (pop_q[q_q]) begin
					ram_re  = 1'b1;
					state_d = ST_POP_OUT;
				end else begin
					state_d = ST_ARM_A;
				end
			end
			ST_POP_OUT: begin
				if (out_free) begin
					emit     = 1'b1;
					ev_d     = (xpick_q[q_q] > cfg_deliver_q) ? EV_DELIVERED : EV_DROP_RAND;
					tagout_d = rd16;
					last_d   = last_pop;
					state_d  = ST_ARM_A;
				end
			end
			ST_ARM_A: begin
				alu_req = '{op: ALU_ADD, a: now_q, b: {16'd0, cfg_base_q}};
				if (fill_cur != '0 && !armed_cur) begin
					state_d = ST_ARM_B;
				end else if (q_q == Q_LAST) begin
					state_d = ST_IDLE;
				end else begin
					q_d     = q_q + 2'd1;
					state_d = ST_QSTART;
				end
			end
			ST_ARM_B: begin
				alu_req = '{op: ALU_ADD, a: acc_q, b: {17'd0, prod_q}};
				if (q_q == Q_LAST) begin
					state_d = ST_IDLE;
				end else begin
					q_d     = q_q + 2'd1;
					state_d = ST_QSTART;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Captured item and arming intermediates.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tag_q      <= packet_tag;
			now_q      <= now_ms;
			dpick_q[0] <= delay_pick_one;
			dpick_q[1] <= delay_pick_two;
			dpick_q[2] <= delay_pick_three;
			xpick_q[0] <= drop_pick_one;
			xpick_q[1] <= drop_pick_two;
			xpick_q[2] <= drop_pick_three;
		end
		if (state_q == ST_ARM_A) begin
			acc_q  <= alu_res.sum;
			prod_q <= 15'(cfg_step_q) * 15'(dpick_q[q_q]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_limit_q   <= LIMIT_RST;
			cfg_base_q    <= BASE_RST;
			cfg_step_q    <= STEP_RST;
			cfg_deliver_q <= DELIVER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_QUEUE_LIMIT:   cfg_limit_q   <= cfg_data[6:0];
				CFG_DELAY_BASE:    cfg_base_q    <= cfg_data;
				CFG_DELAY_STEP:    cfg_step_q    <= cfg_data[7:0];
				CFG_DELIVER_ABOVE: cfg_deliver_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NQ; i++) begin
				rp_q[i]       <= '0;
				fill_q[i]     <= '0;
				deadline_q[i] <= '0;
			end
			armed_q <= '0;
			pop_q   <= '0;
		end else begin
			unique case (state_q)
				ST_ARRIVE: begin
					if (emit && room) begin
						fill_q[q_q] <= fill_cur + CW'(1);
					end
				end
				ST_CMP: begin
					pop_q[q_q] <= (fill_cur != '0) && armed_cur && alu_res.lt;
				end
				ST_POP_OUT: begin
					if (emit) begin
						rp_q[q_q]       <= (rp_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_cur + PW'(1);
						fill_q[q_q]     <= fill_cur - CW'(1);
						armed_q[q_q]    <= 1'b0;
						deadline_q[q_q] <= '0;
					end
				end
				ST_ARM_B: begin
					deadline_q[q_q] <= alu_res.sum;
					armed_q[q_q]    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ev_q     <= ev_d;
			qid_q    <= q_q;
			tagout_q <= tagout_d;
			last_q   <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = ev_q;
	assign queue_id  = qid_q;
	assign tag_out   = tagout_q;
	assign last      = last_q;

	generate
		for (genvar g = 0; g < NQ; g++) begin : g_chk
			a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
				fill_q[g] <= CW'(QUEUE_DEPTH))
				else $error("queue fill exceeds depth");
			a_armed_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
				armed_q[g] |-> fill_q[g] != '0)
				else $error("armed head on an empty queue");
		end
	endgenerate

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_OUT && emit) |-> fill_cur != '0)
		else $error("pop from an empty queue");

	a_arm_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ARM_B |-> $past(state_q) == ST_ARM_A)
		else $error("second arming step without the first");

endmodule
